### rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared widths, constants, register indexes and control structs for the
// motor speed PD controller.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Field widths
  localparam int FRAC_BITS   = 8;
  localparam int PERIOD_BITS = 24;
  localparam int SPEED_W     = 10;
  localparam int CMD_W       = 15;
  localparam int GAIN_W      = 16;
  localparam int OFFS_W      = 18;
  localparam int ERR_W       = 24;

  // Internal widths
  localparam int TNUM_W = 27;  // (speed*2^F - offset)*2^F, signed
  localparam int TGT_W  = 28;  // target RPM, signed Q.8
  localparam int MEAS_W = 25;  // measured RPM, unsigned Q.8
  localparam int E_W    = 29;  // error, signed Q.8
  localparam int EDIF_W = 30;  // error difference, signed Q.8
  localparam int PROD_W = 46;  // multiplier product
  localparam int ACC_W  = 48;  // PD sum, signed Q.16

  // Shared divider
  localparam int DIV_W     = 36;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // RPM = 60e6 / period / 562.25 = 240e6 / (2249 * period)
  localparam logic [DIV_W-1:0] RPM_NUM_Q = 36'd61440000000;  // 240e6 * 2^F
  localparam logic [11:0]      RPM_DEN   = 12'd2249;

  // Command clamp, 120 RPM
  localparam logic [CMD_W-1:0] CMD_MAX = 15'd30720;
  localparam logic [ACC_W-1:0] SUM_MAX = 48'd7864320;

  // Drive saturation bounds
  localparam logic [SPEED_W-1:0] DRIVE_MIN = 10'h200;
  localparam logic [SPEED_W-1:0] DRIVE_MAX = 10'h1FF;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPEED_PER_RPM = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_OFFSET  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WHOLE_ERROR   = 3'd4;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] speed_per_rpm;
    logic [OFFS_W-1:0] speed_offset;
    logic              whole_error;
  } msc_cfg_t;

  typedef enum logic [1:0] {
    MUL_PROP,
    MUL_DERIV,
    MUL_SLOPE
  } msc_mul_sel_t;

  typedef struct packed {
    logic         load_in;
    logic         div_start;
    logic         div_sel;     // 0: measured RPM, 1: target RPM
    logic         store_meas;
    logic         store_tgt;
    logic         calc_err;
    logic         calc_diff;
    logic         mul_en;
    msc_mul_sel_t mul_sel;
    logic         acc_p;
    logic         acc_d;
    logic         clamp;
    logic         load_out;
  } msc_cmd_t;

  typedef struct packed {
    logic div_done;
  } msc_sts_t;

endpackage

### rtl/motor_speed_pd_controller.sv
// ----------------------------------------------------------------------------
// motor_speed_pd_controller
// Per-wheel PD speed loop with feedforward, stream in and out, APB registers.
// ----------------------------------------------------------------------------
// One input beat (commanded drive value, encoder period in microseconds)
// yields one output beat (new drive value, clamped command RPM in Q7.8).
// The block works on one item at a time: each item passes from acceptance to
// the output register through one shared 36-step bit-serial divider that runs
// twice per item (measured RPM, then target RPM), then multiply, accumulate and
// clamp. The output register lets the next item be accepted while a result
// still waits. The user must write registers through the APB port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module motor_speed_pd_controller (
  input  logic                        clk,
  input  logic                        rst,
  // stream in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [39:0]                 s_tdata,   // [9:0] set_speed, [33:10] period_us
  // stream out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [9:0] drive_speed, [24:10] command_rpm
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import msc_pkg::*;

  msc_cfg_t           cfg;
  msc_cmd_t           cmd;
  msc_sts_t           sts;
  logic [IDX_W-1:0]   reg_idx;
  logic               cfg_wr;
  logic [SPEED_W-1:0] drive_speed;
  logic [CMD_W-1:0]   command_rpm;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= 16'sd256;
      cfg.deriv_gain    <= '0;
      cfg.speed_per_rpm <= -16'sd729;
      cfg.speed_offset  <= -18'sd9009;
      cfg.whole_error   <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:     cfg.prop_gain     <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg.deriv_gain    <= pwdata[GAIN_W-1:0];
        REG_SPEED_PER_RPM: cfg.speed_per_rpm <= pwdata[GAIN_W-1:0];
        REG_SPEED_OFFSET:  cfg.speed_offset  <= pwdata[OFFS_W-1:0];
        REG_WHOLE_ERROR:   cfg.whole_error   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register reads, sign extended
  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:     prdata = {{(32-GAIN_W){cfg.prop_gain[GAIN_W-1]}}, cfg.prop_gain};
      REG_DERIV_GAIN:    prdata = {{(32-GAIN_W){cfg.deriv_gain[GAIN_W-1]}}, cfg.deriv_gain};
      REG_SPEED_PER_RPM: prdata = {{(32-GAIN_W){cfg.speed_per_rpm[GAIN_W-1]}},
                                   cfg.speed_per_rpm};
      REG_SPEED_OFFSET:  prdata = {{(32-OFFS_W){cfg.speed_offset[OFFS_W-1]}},
                                   cfg.speed_offset};
      REG_WHOLE_ERROR:   prdata = {31'b0, cfg.whole_error};
      default:           prdata = '0;
    endcase
  end

  msc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .set_speed   (s_tdata[SPEED_W-1:0]),
    .period_us   (s_tdata[SPEED_W+PERIOD_BITS-1:SPEED_W]),
    .drive_speed (drive_speed),
    .command_rpm (command_rpm)
  );

  assign m_tdata = {7'b0, command_rpm, drive_speed};

endmodule

### rtl/msc_div.sv
// ----------------------------------------------------------------------------
// msc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [msc_pkg::DIV_W-1:0] num,
  input  logic [msc_pkg::DIV_W-1:0] den,
  output logic [msc_pkg::DIV_W-1:0] quo,
  output logic                     done
);
  import msc_pkg::*;

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W+1:0]     diff;
  logic                 ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    diff   = {1'b0, rem_sh} - {2'b0, den_r};
    ge     = ~diff[DIV_W+1];
  end

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
      cnt   <= DIV_CNT_W'(DIV_W);
      busy  <= 1'b1;
      done  <= 1'b0;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

### rtl/msc_datapath.sv
// ----------------------------------------------------------------------------
// msc_datapath
// Arithmetic of the speed loop: RPM divisions, error, PD sum, clamp and
// the map back to a drive value, with the output register.
// ----------------------------------------------------------------------------
module msc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  msc_pkg::msc_cfg_t            cfg,
  input  msc_pkg::msc_cmd_t            cmd,
  output msc_pkg::msc_sts_t            sts,
  input  logic [msc_pkg::SPEED_W-1:0]  set_speed,
  input  logic [msc_pkg::PERIOD_BITS-1:0] period_us,
  output logic [msc_pkg::SPEED_W-1:0]  drive_speed,
  output logic [msc_pkg::CMD_W-1:0]    command_rpm
);
  import msc_pkg::*;

  logic [SPEED_W-1:0]     speed_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic [MEAS_W-1:0]      measured_r;
  logic [TGT_W-1:0]       target_r;
  logic [E_W-1:0]         err_r;
  logic [EDIF_W-1:0]      edif_r;
  logic [ERR_W-1:0]       last_error;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;
  logic [CMD_W-1:0]       cmd_r;

  logic [PERIOD_BITS-1:0] period_eff;
  logic [DIV_W-1:0]       den_meas;
  logic [OFFS_W:0]        sp_q;
  logic [TNUM_W-1:0]      tnum;
  logic [TNUM_W-1:0]      tnum_mag;
  logic [GAIN_W-1:0]      slope_mag;
  logic                   q_neg;
  logic [DIV_W-1:0]       div_num;
  logic [DIV_W-1:0]       div_den;
  logic [DIV_W-1:0]       div_quo;
  logic                   div_done;
  logic [TGT_W-1:0]       tgt_mag;
  logic [TGT_W-1:0]       tgt_val;
  logic [E_W-1:0]         err_raw;
  logic [E_W-1:0]         err_base;
  logic [E_W-1:0]         err_val;
  logic [ERR_W-1:0]       last_sat;
  logic [GAIN_W-1:0]      mul_a;
  logic [EDIF_W-1:0]      mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [CMD_W-1:0]       clamp_val;
  logic [PROD_W-1:0]      dsum;
  logic [EDIF_W-1:0]      dq;
  logic [SPEED_W-1:0]     drive_val;

  // Divider operands: measured RPM first, then target RPM magnitude
  always_comb begin
    period_eff = (period_r == '0) ? PERIOD_BITS'(1) : period_r;
    den_meas   = DIV_W'(RPM_DEN) * DIV_W'(period_eff);
    sp_q       = {speed_r[SPEED_W-1], speed_r, FRAC_BITS'(0)}
               - {cfg.speed_offset[OFFS_W-1], cfg.speed_offset};
    tnum       = {sp_q, FRAC_BITS'(0)};
    tnum_mag   = tnum[TNUM_W-1] ? (~tnum + TNUM_W'(1)) : tnum;
    slope_mag  = cfg.speed_per_rpm[GAIN_W-1] ? (~cfg.speed_per_rpm + GAIN_W'(1))
                                             : cfg.speed_per_rpm;
    q_neg      = tnum[TNUM_W-1] ^ cfg.speed_per_rpm[GAIN_W-1];
    div_num    = cmd.div_sel ? DIV_W'(tnum_mag) : RPM_NUM_Q;
    div_den    = cmd.div_sel ? DIV_W'(slope_mag) : den_meas;
  end

  msc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign sts.div_done = div_done;

  // Signed target; zero slope gives zero
  always_comb begin
    tgt_mag = {1'b0, div_quo[TGT_W-2:0]};
    if (cfg.speed_per_rpm == '0) begin
      tgt_val = '0;
    end else if (q_neg) begin
      tgt_val = ~tgt_mag + TGT_W'(1);
    end else begin
      tgt_val = tgt_mag;
    end
  end

  // Error, optionally truncated toward zero to whole RPM
  always_comb begin
    err_raw  = {target_r[TGT_W-1], target_r} - E_W'(measured_r);
    err_base = {err_raw[E_W-1:FRAC_BITS], FRAC_BITS'(0)};
    if (!cfg.whole_error) begin
      err_val = err_raw;
    end else if (err_raw[E_W-1] && (|err_raw[FRAC_BITS-1:0])) begin
      err_val = err_base + E_W'(1 << FRAC_BITS);
    end else begin
      err_val = err_base;
    end
  end

  // Saturate stored error to Q15.8
  always_comb begin
    if ((&err_r[E_W-1:ERR_W-1]) || ~(|err_r[E_W-1:ERR_W-1])) begin
      last_sat = err_r[ERR_W-1:0];
    end else if (err_r[E_W-1]) begin
      last_sat = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      last_sat = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // Shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_PROP: begin
        mul_a = cfg.prop_gain;
        mul_b = {err_r[E_W-1], err_r};
      end
      MUL_DERIV: begin
        mul_a = cfg.deriv_gain;
        mul_b = edif_r;
      end
      MUL_SLOPE: begin
        mul_a = cfg.speed_per_rpm;
        mul_b = EDIF_W'(cmd_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = $signed({{(PROD_W-GAIN_W){mul_a[GAIN_W-1]}}, mul_a})
          * $signed({{(PROD_W-EDIF_W){mul_b[EDIF_W-1]}}, mul_b});
  end

  // Clamp the PD sum to 0..120 RPM
  always_comb begin
    if (acc[ACC_W-1] || (acc == '0)) begin
      clamp_val = '0;
    end else if (acc >= SUM_MAX) begin
      clamp_val = CMD_MAX;
    end else begin
      clamp_val = acc[CMD_W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  // Map back to drive: truncate toward zero, then saturate
  always_comb begin
    dsum = prod + PROD_W'({{(PROD_W-OFFS_W-FRAC_BITS){cfg.speed_offset[OFFS_W-1]}},
                           cfg.speed_offset, FRAC_BITS'(0)});
    dq   = dsum[PROD_W-1:2*FRAC_BITS];
    if (dsum[PROD_W-1] && (|dsum[2*FRAC_BITS-1:0])) begin
      dq = dq + EDIF_W'(1);
    end
    if (dq[EDIF_W-1] && !(&dq[EDIF_W-1:SPEED_W-1])) begin
      drive_val = DRIVE_MIN;
    end else if (!dq[EDIF_W-1] && (|dq[EDIF_W-1:SPEED_W-1])) begin
      drive_val = DRIVE_MAX;
    end else begin
      drive_val = dq[SPEED_W-1:0];
    end
  end

  // Error history
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
    end else if (cmd.calc_diff) begin
      last_error <= last_sat;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      speed_r  <= set_speed;
      period_r <= period_us;
    end
    if (cmd.store_meas) begin
      measured_r <= div_quo[MEAS_W-1:0];
    end
    if (cmd.store_tgt) begin
      target_r <= tgt_val;
    end
    if (cmd.calc_err) begin
      err_r <= err_val;
    end
    if (cmd.calc_diff) begin
      edif_r <= {err_r[E_W-1], err_r}
              - {{(EDIF_W-ERR_W){last_error[ERR_W-1]}}, last_error};
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.acc_p) begin
      acc <= ACC_W'({measured_r, FRAC_BITS'(0)})
           + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end else if (cmd.acc_d) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (cmd.clamp) begin
      cmd_r <= clamp_val;
    end
    if (cmd.load_out) begin
      drive_speed <= drive_val;
      command_rpm <= cmd_r;
    end
  end

endmodule

### rtl/msc_ctrl.sv
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer for one item through the datapath, plus stream handshakes.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  msc_pkg::msc_sts_t  sts,
  output msc_pkg::msc_cmd_t  cmd
);
  import msc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_MEAS,
    ST_WAIT_MEAS,
    ST_WAIT_TGT,
    ST_ERR,
    ST_DIFF,
    ST_ACC_P,
    ST_ACC_D,
    ST_CLAMP,
    ST_MUL_CMD,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = ~out_valid | out_ready;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_PROP;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_START_MEAS;
        end
      end
      ST_START_MEAS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_MEAS;
      end
      ST_WAIT_MEAS: begin
        if (sts.div_done) begin
          cmd.store_meas = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel    = 1'b1;
          state_next     = ST_WAIT_TGT;
        end
      end
      ST_WAIT_TGT: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.store_tgt = 1'b1;
          state_next    = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        state_next   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_PROP;
        state_next    = ST_ACC_P;
      end
      ST_ACC_P: begin
        cmd.acc_p   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DERIV;
        state_next  = ST_ACC_D;
      end
      ST_ACC_D: begin
        cmd.acc_d  = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_MUL_CMD;
      end
      ST_MUL_CMD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SLOPE;
        state_next  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
